### sv/text_console_char_handler_core_assert.svh
// Assertion macros used by the checker file tcch_checker.sv.
`ifndef TEXT_CONSOLE_CHAR_HANDLER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_HANDLER_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define TCCH_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TCCH_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/tcch_pkg.sv
`timescale 1ns / 1ps

package tcch_pkg;

    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = 11;
    localparam int DATA_W      = 16;
    localparam int KIND_W      = 2;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    typedef logic [KIND_W-1:0]     kind_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam kind_t KIND_CURSOR = 2'd0;
    localparam kind_t KIND_WRITE  = 2'd1;
    localparam kind_t KIND_SCROLL = 2'd2;

    localparam cfg_addr_t REG_ATTR   = 1'b0;
    localparam cfg_addr_t REG_SCROLL = 1'b1;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        kind_t             kind;
        logic [CELL_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [CELL_W-1:0] cursor;
        logic              last;
    } result_t;

    typedef struct packed {
        logic en;
        logic two;
    } push_t;

endpackage

### sv/tcch_decode.sv
`timescale 1ns / 1ps

module tcch_decode #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic [tcch_pkg::CHAR_W-1:0]         char_code,
    input  logic [tcch_pkg::ATTR_W-1:0]         attr,
    input  logic                                scroll_en,
    input  logic [$clog2(COLUMNS)-1:0]          col,
    input  logic [$clog2(ROWS)-1:0]             row,
    output logic [$clog2(COLUMNS)-1:0]          next_col,
    output logic [$clog2(ROWS)-1:0]             next_row,
    output tcch_pkg::result_t                   res_a,
    output tcch_pkg::result_t                   res_b,
    output logic                                two
);
    import tcch_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int TAB_W = $clog2(COLUMNS + TAB_WIDTH);

    logic [TAB_W-1:0]  tab_stop_tbl [COLUMNS];
    logic [TAB_W-1:0]  tab_stop;
    logic [COL_W:0]    col_inc;
    logic              wr;
    logic              wrap;
    logic              scroll;
    logic [CELL_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] blank;
    logic [CELL_W-1:0] cursor;

    function automatic logic [CELL_W-1:0] cell_of(input logic [COL_W-1:0] c,
                                                  input logic [ROW_W-1:0] r);
        return CELL_W'(r) * CELL_W'(COLUMNS) + CELL_W'(c);
    endfunction

    for (genvar i = 0; i < COLUMNS; i++)
    begin : g_tab
        assign tab_stop_tbl[i] = TAB_W'(((i / TAB_WIDTH) + 1) * TAB_WIDTH);
    end

    assign tab_stop = tab_stop_tbl[col];
    assign col_inc  = {1'b0, col} + (COL_W+1)'(1);
    assign blank    = {attr, CHAR_SPACE};

    always_comb
    begin
        next_col = col;
        next_row = row;
        wr       = 1'b0;
        wrap     = 1'b0;
        scroll   = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        priority if (char_code == CHAR_LF)
        begin
            wrap = 1'b1;
        end
        else if (char_code == CHAR_BS)
        begin
            if (col != '0)
            begin
                next_col = col - COL_W'(1);
            end
            else if (row != '0)
            begin
                next_col = COL_W'(COLUMNS - 1);
                next_row = row - ROW_W'(1);
            end
            wr      = 1'b1;
            wr_addr = cell_of(next_col, next_row);
            wr_data = blank;
        end
        else if (char_code == CHAR_TAB)
        begin
            if (tab_stop >= TAB_W'(COLUMNS))
                wrap = 1'b1;
            else
                next_col = tab_stop[COL_W-1:0];
        end
        else if (char_code == CHAR_CR)
        begin
            next_col = '0;
        end
        else if (char_code >= CHAR_SPACE && !char_code[CHAR_W-1])
        begin
            wr      = 1'b1;
            wr_addr = cell_of(col, row);
            wr_data = {attr, char_code};
            if (col_inc >= (COL_W+1)'(COLUMNS))
                wrap = 1'b1;
            else
                next_col = col_inc[COL_W-1:0];
        end
        else
        begin
        end

        if (wrap)
        begin
            next_col = '0;
            if (row == ROW_W'(ROWS - 1))
                scroll = scroll_en;
            else
                next_row = row + ROW_W'(1);
        end
    end

    assign cursor = cell_of(next_col, next_row);
    assign two    = wr && scroll;

    always_comb
    begin
        res_b = '{kind: KIND_SCROLL, addr: '0, data: blank, cursor: cursor, last: 1'b1};
        priority if (wr)
            res_a = '{kind: KIND_WRITE, addr: wr_addr, data: wr_data, cursor: cursor,
                      last: !scroll};
        else if (scroll)
            res_a = res_b;
        else
            res_a = '{kind: KIND_CURSOR, addr: '0, data: '0, cursor: cursor, last: 1'b1};
    end

endmodule

### sv/tcch_outq.sv
`timescale 1ns / 1ps

module tcch_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  tcch_pkg::push_t   push,
    input  tcch_pkg::result_t res_a,
    input  tcch_pkg::result_t res_b,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output tcch_pkg::result_t out_res
);
    import tcch_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    pend_valid_reg;
    logic    pend_valid_next;
    result_t out_reg;
    result_t out_next;
    result_t pend_reg;
    result_t pend_next;
    logic    pop;

    assign pop   = out_valid_reg && out_ready;
    assign ready = !out_valid_reg || (out_ready && !pend_valid_reg);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        pend_next       = pend_reg;
        priority if (push.en)
        begin
            out_valid_next  = 1'b1;
            out_next        = res_a;
            pend_valid_next = push.two;
            pend_next       = res_b;
        end
        else if (pop)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

### sv/text_console_char_handler_core.sv
`timescale 1ns / 1ps
// Channel   | Direction | Ports                          | Content
// s_        | in        | s_tvalid s_tready s_tdata      | character byte
// m_        | out       | m_tvalid m_tready m_tdata      | cell write, scroll or cursor
//           |           | m_tuser m_tlast                |   report; tlast ends an input
// cfg_      | in        | cfg_we cfg_addr cfg_data       | attribute, scroll enable
// One character per cycle while m_ does not stall and no byte gives two results;
// a byte passes the input register, then the result register. A printable byte that
// wraps past the last row with scrolling on gives two results, the second held pending.
// Reset clears cursor to cell 0, attribute to 0x0F, scroll enable to 1.
// A stall on m_ propagates back to s_tready once the result and input registers are full.

module text_console_char_handler_core #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tcch_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] char_code
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [10:0] cell_address, [26:11] cell_data, [37:27] cursor_cell, [39:38] zero
    output logic [tcch_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [tcch_pkg::KIND_W-1:0]        m_tuser,   // [1:0] result_kind
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [tcch_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tcch_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tcch_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    logic [ATTR_W-1:0] attr_reg;
    logic              scroll_en_reg;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    result_t           res_a;
    result_t           res_b;
    result_t           out_res;
    logic              two;
    logic              q_ready;
    logic              advance;
    push_t             push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_RESET;
            scroll_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ATTR:   attr_reg      <= cfg_data;
                REG_SCROLL: scroll_en_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign advance  = in_valid_reg && q_ready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            char_reg <= s_tdata[CHAR_W-1:0];
    end

    tcch_decode #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_decode (
        .char_code (char_reg),
        .attr      (attr_reg),
        .scroll_en (scroll_en_reg),
        .col       (col_reg),
        .row       (row_reg),
        .next_col  (col_next),
        .next_row  (row_next),
        .res_a     (res_a),
        .res_b     (res_b),
        .two       (two)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign push = '{en: advance, two: two};

    tcch_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res_a     (res_a),
        .res_b     (res_b),
        .ready     (q_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {2'b00, out_res.cursor, out_res.data, out_res.addr};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

### sv/tcch_checker.sv
`timescale 1ns / 1ps
`include "text_console_char_handler_core_assert.svh"

module tcch_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tcch_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [tcch_pkg::KIND_W-1:0]      m_tuser,
    input logic                             m_tlast
);
    import tcch_pkg::*;

    `TCCH_ASSERT(a_hold_on_stall, clk, rst_n,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast)),
        "result changed while stalled")
    `TCCH_ASSERT(a_only_write_continues, clk, rst_n,
        (m_tvalid && !m_tlast) |-> (m_tuser == KIND_WRITE),
        "non-final result is not a cell write")
    `TCCH_ASSERT(a_second_follows, clk, rst_n,
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == KIND_SCROLL && m_tlast),
        "scroll did not follow a wrapping write")
    `TCCH_ASSERT(a_cursor_report_clean, clk, rst_n,
        (m_tvalid && m_tuser == KIND_CURSOR) |-> (m_tlast && m_tdata[26:0] == 27'd0),
        "cursor report carries cell data")
    `TCCH_ASSERT_ALWAYS(a_reset_idle, clk,
        !rst_n |-> (m_tvalid !== 1'b1),
        "result shown during reset")

endmodule

bind text_console_char_handler_core tcch_checker u_tcch_checker (.*);

### tb/text_console_char_handler_checker.sv
`timescale 1ns / 1ps

module text_console_char_handler_checker #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [tcch_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] char_code
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // [10:0] cell_address, [26:11] cell_data, [37:27] cursor_cell, [39:38] zero
    input  logic [tcch_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic [tcch_pkg::KIND_W-1:0]        m_tuser,   // [1:0] result_kind
    input  logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [tcch_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tcch_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);

    import tcch_pkg::*;

    localparam logic [CHAR_W-1:0] CHAR_HIGH = 8'h80;

    logic [ATTR_W-1:0] attr;
    logic              scroll_on;
    logic [6:0]        col;
    logic [4:0]        row;
    result_t           cell_ops_q[$];
    result_t           want;

    function automatic logic [CELL_W-1:0] cell_of(logic [6:0] c, logic [4:0] r);
        return CELL_W'(int'(r) * COLUMNS + int'(c));
    endfunction

    function automatic result_t make_op(kind_t kind, logic [CELL_W-1:0] addr,
                                        logic [DATA_W-1:0] data);
        result_t op;
        op        = '0;
        op.kind   = kind;
        op.addr   = addr;
        op.data   = data;
        return op;
    endfunction

    // advance to column 0 of the next row; report whether the screen scrolls
    function automatic logic wrap_row();
        col = '0;
        if (int'(row) + 1 >= ROWS) begin
            row = 5'(ROWS - 1);
            return scroll_on;
        end
        row = row + 5'd1;
        return 1'b0;
    endfunction

    task automatic render_char(logic [CHAR_W-1:0] c);
        result_t           ops[2];
        int                n;
        int                tab_col;
        logic              scroll;
        logic [DATA_W-1:0] blank;
        n      = 0;
        scroll = 1'b0;
        blank  = {attr, CHAR_SPACE};
        if (c == CHAR_LF) begin
            scroll = wrap_row();
        end
        else if (c == CHAR_BS) begin
            if (col > 0) begin
                col = col - 7'd1;
            end
            else if (row > 0) begin
                col = 7'(COLUMNS - 1);
                row = row - 5'd1;
            end
            ops[n] = make_op(KIND_WRITE, cell_of(col, row), blank);
            n++;
        end
        else if (c == CHAR_TAB) begin
            tab_col = (int'(col) / TAB_WIDTH + 1) * TAB_WIDTH;
            if (tab_col >= COLUMNS)
                scroll = wrap_row();
            else
                col = 7'(tab_col);
        end
        else if (c == CHAR_CR) begin
            col = '0;
        end
        else if (c >= CHAR_SPACE && c < CHAR_HIGH) begin
            ops[n] = make_op(KIND_WRITE, cell_of(col, row), {attr, c});
            n++;
            col = col + 7'd1;
            if (int'(col) >= COLUMNS)
                scroll = wrap_row();
        end
        if (scroll) begin
            ops[n] = make_op(KIND_SCROLL, '0, blank);
            n++;
        end
        if (n == 0) begin
            ops[n] = make_op(KIND_CURSOR, '0, '0);
            n++;
        end
        for (int i = 0; i < n; i++) begin
            ops[i].cursor = cell_of(col, row);
            ops[i].last   = (i == n - 1);
            cell_ops_q.push_back(ops[i]);
        end
    endtask

    task automatic check_field(string name, int unsigned expected, int unsigned actual);
        if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            attr       = ATTR_RESET;
            scroll_on  = 1'b1;
            col        = '0;
            row        = '0;
            mismatches = 0;
            cell_ops_q.delete();
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_addr == REG_ATTR)
                    attr = cfg_data;
                else if (cfg_addr == REG_SCROLL)
                    scroll_on = cfg_data[0];
            end
            if (m_tvalid && m_tready) begin
                if (cell_ops_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end
                else begin
                    want = cell_ops_q.pop_front();
                    check_field("result_kind", want.kind, m_tuser);
                    check_field("cell_address", want.addr, m_tdata[10:0]);
                    check_field("cell_data", want.data, m_tdata[26:11]);
                    check_field("cursor_cell", want.cursor, m_tdata[37:27]);
                    check_field("last_result", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                render_char(s_tdata[CHAR_W-1:0]);
            outstanding <= cell_ops_q.size();
        end
    end

endmodule

### tb/text_console_char_handler_core_tb.sv
`timescale 1ns / 1ps

module text_console_char_handler_core_tb;

    import tcch_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TAB_WIDTH   = 4;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 165;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 400000;

    localparam int MIX_TEXT  = 0;
    localparam int MIX_TABS  = 1;
    localparam int MIX_ERASE = 2;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;
    logic                   cfg_we   = 1'b0;
    cfg_addr_t              cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int burst_left = 0;
    int hold_token = 0;

    // origin backspace, field extremes, control codes, then the wrap cases
    logic [CHAR_W-1:0] directed_chars [17] = '{
        CHAR_BS, 8'h41, CHAR_SPACE, 8'h7F, 8'h1F, 8'h00, 8'h80, 8'hFF,
        CHAR_TAB, CHAR_CR, CHAR_LF, CHAR_BS, CHAR_TAB, CHAR_BS, 8'h5A,
        CHAR_LF, CHAR_CR
    };

    text_console_char_handler_core #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    text_console_char_handler_checker #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) console_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .mismatches  (fail_count),
        .outstanding (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [CHAR_W-1:0] pick_char(int mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_TEXT:
            begin
                if (r < 8)       return CHAR_LF;
                else if (r < 11) return CHAR_CR;
                else if (r < 15) return CHAR_BS;
                else if (r < 19) return CHAR_TAB;
                else if (r < 23) return CHAR_W'($urandom_range(0, 255));
            end
            MIX_TABS:
            begin
                if (r < 1)       return CHAR_LF;
                else if (r < 25) return CHAR_TAB;
                else if (r < 28) return CHAR_BS;
                else if (r < 32) return CHAR_W'($urandom_range(0, 255));
            end
            default:
            begin
                if (r < 5)       return CHAR_LF;
                else if (r < 40) return CHAR_BS;
                else if (r < 45) return CHAR_CR;
                else if (r < 55) return CHAR_W'($urandom_range(0, 255));
            end
        endcase
        return CHAR_W'($urandom_range(32, 127));
    endfunction

    task automatic send_char(logic [CHAR_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(cfg_addr_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // drain every expected transaction, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int hold_seen;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] attr;
        int                    mix;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_chars[i])
            send_char(directed_chars[i]);
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0:       attr = 8'h00;
                1, 6:    attr = 8'hFF;
                default: attr = CFG_DATA_W'($urandom_range(0, 255));
            endcase
            write_reg(REG_ATTR, attr);
            write_reg(REG_SCROLL, (phase == 1 || phase == 3 || phase == 7) ? 8'd0 : 8'd1);
            mix = phase % 3;
            if (phase == 2) begin
                // hold the receiver off and keep offering back to back
                hold_token <= hold_token + 1;
                burst_left = 80;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_char(pick_char(mix));
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/tcch_pkg.sv
sv/tcch_decode.sv
sv/tcch_outq.sv
sv/text_console_char_handler_core.sv
sv/tcch_checker.sv
tb/text_console_char_handler_checker.sv
tb/text_console_char_handler_core_tb.sv
